@@ src/jisq_pkg.sv @@
// ----------------------------------------------------------------------------
// jisq_pkg: shared types and constants for the JTAG IR scan sequencer
// Scan descriptor, sequencer phases, TAP state codes and the TAP
// next-state function.
// ----------------------------------------------------------------------------
package jisq_pkg;

   // Bounds on the configured counts
   localparam int MAX_LEADING_BITS  = 16;
   localparam int MAX_IR_BITS       = 32;
   localparam int MAX_TRAILING_BITS = 10;

   // Field widths
   localparam int CODE_W     = 32;
   localparam int LEAD_W     = 5;
   localparam int IRLEN_W    = 6;
   localparam int TRAIL_W    = 4;
   localparam int CNT_W      = 5;
   localparam int TAP_W      = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Descriptor queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Saturation values at field width
   localparam logic [LEAD_W-1:0]  LEAD_MAX_VAL  = LEAD_W'(MAX_LEADING_BITS);
   localparam logic [IRLEN_W-1:0] IRLEN_MAX_VAL = IRLEN_W'(MAX_IR_BITS);
   localparam logic [TRAIL_W-1:0] TRAIL_MAX_VAL = TRAIL_W'(MAX_TRAILING_BITS);

   // Register reset values
   localparam logic [LEAD_W-1:0]  LEAD_RESET  = '0;
   localparam logic [IRLEN_W-1:0] IRLEN_RESET = IRLEN_W'(8);
   localparam logic [TRAIL_W-1:0] TRAIL_RESET = '0;

   // Register indexes (paddr[3:2])
   localparam logic [1:0] REG_LEADING  = 2'd0;
   localparam logic [1:0] REG_IRLEN    = 2'd1;
   localparam logic [1:0] REG_TRAILING = 2'd2;

   // Head of the scan: TMS 1,1,0,0
   localparam logic [CNT_W-1:0] HEAD_LAST = CNT_W'(3);

   // TAP state codes
   localparam logic [TAP_W-1:0] TAP_RESET      = 4'd0;
   localparam logic [TAP_W-1:0] TAP_IDLE       = 4'd1;
   localparam logic [TAP_W-1:0] TAP_SELECT_DR  = 4'd2;
   localparam logic [TAP_W-1:0] TAP_CAPTURE_DR = 4'd3;
   localparam logic [TAP_W-1:0] TAP_SHIFT_DR   = 4'd4;
   localparam logic [TAP_W-1:0] TAP_EXIT1_DR   = 4'd5;
   localparam logic [TAP_W-1:0] TAP_PAUSE_DR   = 4'd6;
   localparam logic [TAP_W-1:0] TAP_EXIT2_DR   = 4'd7;
   localparam logic [TAP_W-1:0] TAP_UPDATE_DR  = 4'd8;
   localparam logic [TAP_W-1:0] TAP_SELECT_IR  = 4'd9;
   localparam logic [TAP_W-1:0] TAP_CAPTURE_IR = 4'd10;
   localparam logic [TAP_W-1:0] TAP_SHIFT_IR   = 4'd11;
   localparam logic [TAP_W-1:0] TAP_EXIT1_IR   = 4'd12;
   localparam logic [TAP_W-1:0] TAP_PAUSE_IR   = 4'd13;
   localparam logic [TAP_W-1:0] TAP_EXIT2_IR   = 4'd14;
   localparam logic [TAP_W-1:0] TAP_UPDATE_IR  = 4'd15;

   // One scan, with counts already saturated
   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [LEAD_W-1:0]  lead;
      logic [IRLEN_W-1:0] irlen;
      logic [TRAIL_W-1:0] trail;
   } scan_desc_type;

   // Sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEAD,
      PH_LEAD,
      PH_IR,
      PH_TRAIL,
      PH_UPDATE,
      PH_RUN
   } phase_type;

   // IEEE 1149.1 TAP next state
   function automatic logic [TAP_W-1:0] tap_next(input logic [TAP_W-1:0] st,
                                                  input logic tms);
      case (st)
         TAP_RESET:      return tms ? TAP_RESET     : TAP_IDLE;
         TAP_IDLE:       return tms ? TAP_SELECT_DR : TAP_IDLE;
         TAP_SELECT_DR:  return tms ? TAP_SELECT_IR : TAP_CAPTURE_DR;
         TAP_CAPTURE_DR: return tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
         TAP_SHIFT_DR:   return tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
         TAP_EXIT1_DR:   return tms ? TAP_UPDATE_DR : TAP_PAUSE_DR;
         TAP_PAUSE_DR:   return tms ? TAP_EXIT2_DR  : TAP_PAUSE_DR;
         TAP_EXIT2_DR:   return tms ? TAP_UPDATE_DR : TAP_SHIFT_DR;
         TAP_UPDATE_DR:  return tms ? TAP_SELECT_DR : TAP_IDLE;
         TAP_SELECT_IR:  return tms ? TAP_RESET     : TAP_CAPTURE_IR;
         TAP_CAPTURE_IR: return tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
         TAP_SHIFT_IR:   return tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
         TAP_EXIT1_IR:   return tms ? TAP_UPDATE_IR : TAP_PAUSE_IR;
         TAP_PAUSE_IR:   return tms ? TAP_EXIT2_IR  : TAP_PAUSE_IR;
         TAP_EXIT2_IR:   return tms ? TAP_UPDATE_IR : TAP_SHIFT_IR;
         TAP_UPDATE_IR:  return tms ? TAP_SELECT_DR : TAP_IDLE;
         default:        return TAP_RESET;
      endcase
   endfunction

endpackage

@@ src/jisq_front.sv @@
// ----------------------------------------------------------------------------
// jisq_front: input stage of the IR scan sequencer
// Accepts instruction codes, saturates the configured counts and holds
// one scan descriptor until the queue takes it.
// ----------------------------------------------------------------------------
module jisq_front
   import jisq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [CODE_W-1:0]   in_code,
   input  logic [LEAD_W-1:0]   cfg_lead,
   input  logic [IRLEN_W-1:0]  cfg_irlen,
   input  logic [TRAIL_W-1:0]  cfg_trail,
   output logic                desc_valid,
   input  logic                desc_ready,
   output scan_desc_type       desc
);

   logic          valid_ff, valid_in;
   scan_desc_type desc_ff, desc_in;
   logic          take;

   // Saturated counts; a zero length counts as one bit
   always_comb begin
      desc_in.code  = in_code;
      desc_in.lead  = (cfg_lead > LEAD_MAX_VAL) ? LEAD_MAX_VAL : cfg_lead;
      desc_in.trail = (cfg_trail > TRAIL_MAX_VAL) ? TRAIL_MAX_VAL : cfg_trail;
      if (cfg_irlen == '0)
         desc_in.irlen = IRLEN_W'(1);
      else if (cfg_irlen > IRLEN_MAX_VAL)
         desc_in.irlen = IRLEN_MAX_VAL;
      else
         desc_in.irlen = cfg_irlen;
   end

   assign in_ready = !valid_ff || desc_ready;
   assign take     = in_valid && in_ready;
   assign valid_in = take || (valid_ff && !desc_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         desc_ff <= desc_in;
      end
   end

   assign desc_valid = valid_ff;
   assign desc       = desc_ff;

endmodule

@@ src/jisq_queue.sv @@
// ----------------------------------------------------------------------------
// jisq_queue: descriptor queue
// Short FIFO between the front stage and the sequencer.
// ----------------------------------------------------------------------------
module jisq_queue
   import jisq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  scan_desc_type push_data,
   output logic          pop_valid,
   input  logic          pop,
   output scan_desc_type pop_data
);

   scan_desc_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]        count_ff, count_in;
   logic                     do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      if (do_pop)  rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      if (do_push && !do_pop)
         count_in = count_ff + QCNT_W'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];

endmodule

@@ src/jisq_back.sv @@
// ----------------------------------------------------------------------------
// jisq_back: scan sequencer
// Plays out the TMS/TDI pairs of one scan per descriptor, tracks the TAP
// state and drives the registered result channel.
// ----------------------------------------------------------------------------
module jisq_back
   import jisq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             desc_valid,
   output logic             desc_pop,
   input  scan_desc_type    desc,
   output logic             out_valid,
   input  logic             out_ready,
   output logic             out_tms,
   output logic             out_tdi,
   output logic [TAP_W-1:0] out_tap,
   output logic             out_last
);

   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   scan_desc_type      desc_ff;
   logic [CODE_W-1:0]  shift_ff;
   logic [TAP_W-1:0]   tap_ff, tap_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_tms_ff, rsp_tdi_ff, rsp_last_ff;
   logic [TAP_W-1:0]   rsp_tap_ff;
   logic               out_free, advance, load;
   logic               tms, tdi, last;
   logic [CNT_W-1:0]   lead_last, ir_last, trail_last;

   assign out_free = !rsp_valid_ff || out_ready;
   assign advance  = (phase_ff != PH_IDLE) && out_free;

   // Last count of each counted phase
   assign lead_last  = CNT_W'(desc_ff.lead - LEAD_W'(1));
   assign ir_last    = CNT_W'(desc_ff.irlen - IRLEN_W'(1));
   assign trail_last = CNT_W'(desc_ff.trail - TRAIL_W'(1));

   // Take the next descriptor when idle or on the final pair of a scan
   assign load     = desc_valid &&
                     ((phase_ff == PH_IDLE) || (phase_ff == PH_RUN && advance));
   assign desc_pop = load;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      case (phase_ff)
         PH_IDLE: begin
            phase_in = PH_IDLE;
         end
         PH_HEAD: begin
            if (advance) begin
               if (cnt_ff == HEAD_LAST) begin
                  cnt_in   = '0;
                  phase_in = (desc_ff.lead != '0) ? PH_LEAD : PH_IR;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         PH_LEAD: begin
            if (advance) begin
               if (cnt_ff == lead_last) begin
                  cnt_in   = '0;
                  phase_in = PH_IR;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         PH_IR: begin
            if (advance) begin
               if (cnt_ff == ir_last) begin
                  cnt_in   = '0;
                  phase_in = (desc_ff.trail != '0) ? PH_TRAIL : PH_UPDATE;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         PH_TRAIL: begin
            if (advance) begin
               if (cnt_ff == trail_last) begin
                  cnt_in   = '0;
                  phase_in = PH_UPDATE;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         PH_UPDATE: begin
            if (advance) phase_in = PH_RUN;
         end
         PH_RUN: begin
            if (advance) phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      if (load) begin
         phase_in = PH_HEAD;
         cnt_in   = '0;
      end
   end

   // Pair driven in the current phase
   always_comb begin
      tms  = 1'b0;
      tdi  = 1'b1;
      last = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            tms = 1'b0;
         end
         PH_HEAD: begin
            tms = (cnt_ff < CNT_W'(2));
            tdi = 1'b0;
         end
         PH_LEAD: begin
            tms = 1'b0;
         end
         PH_IR: begin
            tdi = shift_ff[0];
            tms = (cnt_ff == ir_last) && (desc_ff.trail == '0);
         end
         PH_TRAIL: begin
            tms = (cnt_ff == trail_last);
         end
         PH_UPDATE: begin
            tms = 1'b1;
         end
         PH_RUN: begin
            last = 1'b1;
         end
         default: begin
            tms = 1'b0;
         end
      endcase
   end

   assign tap_in       = advance ? tap_next(tap_ff, tms) : tap_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         tap_ff       <= TAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Descriptor and instruction shifter
   always_ff @(posedge clock) begin
      if (load) begin
         desc_ff  <= desc;
         shift_ff <= desc.code;
      end else if (advance && phase_ff == PH_IR) begin
         shift_ff <= shift_ff >> 1;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tms_ff  <= tms;
         rsp_tdi_ff  <= tdi;
         rsp_tap_ff  <= tap_next(tap_ff, tms);
         rsp_last_ff <= last;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_tms   = rsp_tms_ff;
   assign out_tdi   = rsp_tdi_ff;
   assign out_tap   = rsp_tap_ff;
   assign out_last  = rsp_last_ff;

   // A descriptor is only taken from a non-empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      desc_pop |-> desc_valid)
      else $error("descriptor popped from empty queue");

   // Leading phase is only entered with a nonzero count
   a_lead_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEAD) |-> (desc_ff.lead != '0) && (cnt_ff < lead_last + CNT_W'(1)))
      else $error("leading phase count out of range");

   // Instruction bit count stays below the length
   a_ir_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IR) |-> ({1'b0, cnt_ff} < desc_ff.irlen))
      else $error("instruction bit count out of range");

   // Trailing phase is only entered with a nonzero count
   a_trail_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TRAIL) |-> (desc_ff.trail != '0))
      else $error("trailing phase with zero count");

   // Update-IR pair is always followed by the final run pair
   a_update_then_run: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_UPDATE && advance) |=> (phase_ff == PH_RUN))
      else $error("update not followed by run pair");

endmodule

@@ src/jtag_ir_scan_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// jtag_ir_scan_sequencer_unit: JTAG instruction-register scan sequencer
// Turns each instruction code into the TMS/TDI pairs of an IR scan.
// ----------------------------------------------------------------------------
// Each accepted code yields 4 + lead + irlen + trail + 2 result items, one
// per clock while the result side keeps up (7 to 64 with the register
// bounds); the sequencer emitting one pair a clock sets that figure. A
// waiting descriptor is taken on a scan's final pair, leaving no idle pair.
// The input stage and a two-entry descriptor queue take up to three further
// codes while a scan plays out. Counts are saturated at acceptance (lead
// 16, trail 10, length 1..32); registers are to be written only while the
// block is idle; the block does not enforce it. tap_state follows the IEEE
// 1149.1 table from the previous scan's state, starting at test-logic-reset.
// ----------------------------------------------------------------------------
module jtag_ir_scan_sequencer_unit
   import jisq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Instruction items
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // [31:0] instruction_code
   // Scan pairs
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [0] mode_select, [1] data_out,
                                               // [5:2] tap_state, [7:6] zero
   output logic                   rsp_tlast,   // last
   // Register port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [LEAD_W-1:0]  lead_ff;
   logic [IRLEN_W-1:0] irlen_ff;
   logic [TRAIL_W-1:0] trail_ff;
   logic               csr_write;
   logic [1:0]         reg_index;

   logic               fr_valid, fr_ready;
   scan_desc_type      fr_desc;
   logic               q_valid, q_pop;
   scan_desc_type      q_desc;
   logic               o_tms, o_tdi;
   logic [TAP_W-1:0]   o_tap;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= LEAD_RESET;
         irlen_ff <= IRLEN_RESET;
         trail_ff <= TRAIL_RESET;
      end else if (csr_write) begin
         case (reg_index)
            REG_LEADING:  lead_ff  <= csr_pwdata[LEAD_W-1:0];
            REG_IRLEN:    irlen_ff <= csr_pwdata[IRLEN_W-1:0];
            REG_TRAILING: trail_ff <= csr_pwdata[TRAIL_W-1:0];
            default:      ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (reg_index)
         REG_LEADING:  csr_prdata = CSR_DATA_W'(lead_ff);
         REG_IRLEN:    csr_prdata = CSR_DATA_W'(irlen_ff);
         REG_TRAILING: csr_prdata = CSR_DATA_W'(trail_ff);
         default:      csr_prdata = '0;
      endcase
   end

   jisq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_code    (req_tdata),
      .cfg_lead   (lead_ff),
      .cfg_irlen  (irlen_ff),
      .cfg_trail  (trail_ff),
      .desc_valid (fr_valid),
      .desc_ready (fr_ready),
      .desc       (fr_desc)
   );

   jisq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  (fr_desc),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_desc)
   );

   jisq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (q_valid),
      .desc_pop   (q_pop),
      .desc       (q_desc),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_tms    (o_tms),
      .out_tdi    (o_tdi),
      .out_tap    (o_tap),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, o_tap, o_tdi, o_tms};

endmodule
